[hdl/bitmap_block_allocator_top_assert.svh]
// Assertion macros for the bitmap block allocator checker.
// Needs nothing else; include with the bare file name.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Generic form: clock, active-low reset, property and message given.
`define BBA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default form on the block's clock and reset.
`define BBA_ASSERT(lbl, prop, msg) `BBA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hdl/bba_pkg.sv]
// Shared types and constants of the bitmap block allocator.
// No dependencies; used by every module of the block.
package bba_pkg;

  localparam int unsigned CFG_W              = 13;
  localparam int unsigned BLOCK_ID_W         = 12;
  localparam int unsigned NUM_BLOCKS_DEF     = 4096;
  localparam int unsigned SCAN_WORD_BITS_DEF = 64;

  localparam logic [CFG_W-1:0] MAX_BLOCKS_RST = 13'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [BLOCK_ID_W-1:0] block_id;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [BLOCK_ID_W-1:0] alloc_id;
    logic                  error;
  } rsp_t;

  typedef enum logic [2:0] {
    RSP_NONE,
    RSP_FREE,
    RSP_BUMP,
    RSP_HIT,
    RSP_MISS
  } rsp_kind_e;

  typedef struct packed {
    logic      clr_wr;
    logic      capture;
    logic      rd_tgt;
    logic      scan_start;
    logic      scan_next;
    logic      wr_tgt;
    logic      wr_hit;
    rsp_kind_e rsp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic free_ok;
    logic bump_ok;
    logic limit_zero;
    logic scan_hit;
    logic scan_last;
  } ctrl_sts_t;

endpackage

[hdl/bba_ctrl.sv]
// Controller of the bitmap block allocator: sequences clear, lookup and scan.
// Depends on bba_pkg for the command and status structs.
module bba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bba_pkg::ctrl_sts_t  sts_i,
  output bba_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_MODIFY,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
          busy_d  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
          busy_d        = 1'b1;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.is_free) begin
          if (sts_i.free_ok) begin
            cmd_o.rd_tgt = 1'b1;
            state_d      = ST_MODIFY;
          end else begin
            cmd_o.rsp = bba_pkg::RSP_FREE;
            state_d   = ST_IDLE;
            busy_d    = 1'b0;
          end
        end else if (sts_i.bump_ok) begin
          cmd_o.rd_tgt = 1'b1;
          state_d      = ST_MODIFY;
        end else if (sts_i.limit_zero) begin
          cmd_o.rsp = bba_pkg::RSP_MISS;
          state_d   = ST_IDLE;
          busy_d    = 1'b0;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_MODIFY: begin
        cmd_o.wr_tgt = 1'b1;
        cmd_o.rsp    = sts_i.is_free ? bba_pkg::RSP_FREE : bba_pkg::RSP_BUMP;
        state_d      = ST_IDLE;
        busy_d       = 1'b0;
      end
      ST_SCAN: begin
        if (sts_i.scan_hit) begin
          cmd_o.wr_hit = 1'b1;
          cmd_o.rsp    = bba_pkg::RSP_HIT;
          state_d      = ST_IDLE;
          busy_d       = 1'b0;
        end else if (sts_i.scan_last) begin
          cmd_o.rsp = bba_pkg::RSP_MISS;
          state_d   = ST_IDLE;
          busy_d    = 1'b0;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

[hdl/bba_dp.sv]
// Datapath of the bitmap block allocator: used-bit memory, counters, scan logic.
// Depends on bba_pkg for payload, command and status types.
module bba_dp #(
  parameter int unsigned NUM_BLOCKS     = bba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned SCAN_WORD_BITS = bba_pkg::SCAN_WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bba_pkg::req_t                 req_i,
  input  logic                          cfg_valid_i,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_data_i,
  input  bba_pkg::ctrl_cmd_t            cmd_i,
  output bba_pkg::ctrl_sts_t            sts_o,
  output logic                          rsp_valid_o,
  output bba_pkg::rsp_t                 rsp_o
);

  localparam int unsigned W          = SCAN_WORD_BITS;
  localparam int unsigned IDX_W      = $clog2(W);
  localparam int unsigned NUM_WORDS  = (NUM_BLOCKS + W - 1) / W;
  localparam int unsigned AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned ID_W       = $clog2(NUM_BLOCKS);
  localparam int unsigned NB_W       = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CNT_W      = (NB_W > bba_pkg::CFG_W) ? NB_W : bba_pkg::CFG_W;

  // Used-bit store, one word per scan step.
  logic [W-1:0] mem [NUM_WORDS];

  logic [bba_pkg::CFG_W-1:0] max_q, nf_q;
  logic [AW-1:0]             clr_addr_q, scan_word_q, tgt_word_q;
  logic [CNT_W-1:0]          base_q;
  logic [IDX_W-1:0]          tgt_bit_q;
  logic [W-1:0]              rdata_q;
  bba_pkg::req_t             req_q;
  bba_pkg::rsp_t             rsp_q, rsp_d;
  logic                      rsp_valid_q;

  logic [CNT_W-1:0] eff, limit, rem, hit_id;
  logic [CNT_W:0]   next_base;
  logic             is_free, free_ok, bump_ok, hit, last;
  logic [ID_W-1:0]  tgt_id;
  logic [AW-1:0]    tgt_word;
  logic [IDX_W-1:0] tgt_bit, idx;
  logic [W-1:0]     mask, free_bits;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [W-1:0]     mem_wdata;

  // Effective block count and the byte-aligned search limit.
  assign eff   = (CNT_W'(max_q) < CNT_W'(NUM_BLOCKS)) ? CNT_W'(max_q) : CNT_W'(NUM_BLOCKS);
  assign limit = {eff[CNT_W-1:3], 3'b000};

  assign is_free = (req_q.op == bba_pkg::OP_FREE);
  assign free_ok = (req_q.block_id != '0) && (CNT_W'(req_q.block_id) < CNT_W'(NUM_BLOCKS));
  assign bump_ok = (CNT_W'(nf_q) < eff);

  assign tgt_id   = is_free ? ID_W'(req_q.block_id) : ID_W'(nf_q);
  assign tgt_word = AW'(tgt_id >> IDX_W);
  assign tgt_bit  = IDX_W'(tgt_id);

  // Scan step: mask ids at or past the limit, then pick the lowest clear bit.
  assign rem       = limit - base_q;
  assign next_base = (CNT_W + 1)'(base_q + W);
  assign last      = (next_base >= {1'b0, limit});

  always_comb begin
    for (int k = 0; k < W; k++) begin
      mask[k] = (CNT_W'(k) < rem);
    end
  end

  assign free_bits = ~rdata_q & mask;
  assign hit       = |free_bits;

  always_comb begin
    idx = '0;
    for (int k = W - 1; k >= 0; k--) begin
      if (free_bits[k]) begin
        idx = IDX_W'(k);
      end
    end
  end

  assign hit_id = base_q + CNT_W'(idx);

  // Memory port steering.
  assign mem_we = cmd_i.clr_wr | cmd_i.wr_tgt | cmd_i.wr_hit;
  assign mem_re = cmd_i.rd_tgt | cmd_i.scan_start | cmd_i.scan_next;

  always_comb begin
    if (cmd_i.clr_wr) begin
      mem_waddr = clr_addr_q;
      mem_wdata = (clr_addr_q == '0) ? W'(1) : '0;
    end else if (cmd_i.wr_tgt) begin
      mem_waddr = tgt_word_q;
      mem_wdata = is_free ? (rdata_q & ~(W'(1) << tgt_bit_q))
                          : (rdata_q | (W'(1) << tgt_bit_q));
    end else begin
      mem_waddr = scan_word_q;
      mem_wdata = rdata_q | (W'(1) << idx);
    end
  end

  always_comb begin
    if (cmd_i.rd_tgt) begin
      mem_raddr = tgt_word;
    end else if (cmd_i.scan_start) begin
      mem_raddr = '0;
    end else begin
      mem_raddr = scan_word_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Result formatting.
  always_comb begin
    rsp_d = '0;
    case (cmd_i.rsp)
      bba_pkg::RSP_FREE: begin
        rsp_d.found = 1'b1;
      end
      bba_pkg::RSP_BUMP: begin
        rsp_d.found    = 1'b1;
        rsp_d.alloc_id = bba_pkg::BLOCK_ID_W'(nf_q);
        rsp_d.error    = rdata_q[tgt_bit_q];
      end
      bba_pkg::RSP_HIT: begin
        rsp_d.found    = 1'b1;
        rsp_d.alloc_id = bba_pkg::BLOCK_ID_W'(hit_id);
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      max_q       <= bba_pkg::MAX_BLOCKS_RST;
      nf_q        <= bba_pkg::CFG_W'(1);
      scan_word_q <= '0;
      base_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      if (cmd_i.wr_tgt && !is_free) begin
        nf_q <= nf_q + bba_pkg::CFG_W'(1);
      end
      if (cmd_i.scan_start) begin
        scan_word_q <= '0;
        base_q      <= '0;
      end else if (cmd_i.scan_next) begin
        scan_word_q <= scan_word_q + AW'(1);
        base_q      <= CNT_W'(next_base);
      end
      rsp_valid_q <= (cmd_i.rsp != bba_pkg::RSP_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.rd_tgt) begin
      tgt_word_q <= tgt_word;
      tgt_bit_q  <= tgt_bit;
    end
    if (cmd_i.rsp != bba_pkg::RSP_NONE) begin
      rsp_q <= rsp_d;
    end
  end

  assign sts_o.clr_done   = (clr_addr_q == AW'(NUM_WORDS - 1));
  assign sts_o.is_free    = is_free;
  assign sts_o.free_ok    = free_ok;
  assign sts_o.bump_ok    = bump_ok;
  assign sts_o.limit_zero = (limit == '0);
  assign sts_o.scan_hit   = hit;
  assign sts_o.scan_last  = last;

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[hdl/bitmap_block_allocator_top.sv]
// Top level of the bitmap block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl and bba_dp.
//
// First-fit allocator of fixed-size blocks, one used bit per block id. Raise
// start with an item on req_i (op 0 allocate, op 1 free block_id); the item
// is taken at an edge where busy is low. Each item gives exactly one result
// on rsp_o, shown for a single cycle with rsp_valid_o high; there is no
// back-pressure, so sample it when the strobe is up. An allocate hands out
// fresh ids 1, 2, ... while they stay below min(max_blocks, NUM_BLOCKS),
// then searches the used map from id 0 upward over the byte-aligned range.
// A free or a fresh-id allocate runs dispatch, read and read-modify-write
// before the next item can be taken; a free of block 0 or of an id past
// the store skips the map. A search reads one word of SCAN_WORD_BITS bits
// per cycle through the used map until the hit or the end of the range,
// and takes no new item before it is through. After reset a clearing pass
// writes every map word once, with busy held high; block 0 comes out
// reserved. The max_blocks register is written through cfg_valid_i/cfg_data_i
// at any time (cfg_ready_o is always high) but should change only while the
// block is idle. SCAN_WORD_BITS must be a power of two, and NUM_BLOCKS may
// not exceed 4096, the reach of the 12-bit block ids.
module bitmap_block_allocator_top #(
  parameter int unsigned NUM_BLOCKS     = bba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned SCAN_WORD_BITS = bba_pkg::SCAN_WORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  bba_pkg::req_t             req_i,
  output logic                      rsp_valid_o,
  output bba_pkg::rsp_t             rsp_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bba_pkg::CFG_W-1:0] cfg_data_i
);

  bba_pkg::ctrl_cmd_t cmd;
  bba_pkg::ctrl_sts_t sts;

  // Register writes never stall.
  assign cfg_ready_o = 1'b1;

  // Sequencer: clear pass, then one item at a time.
  bba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Used map, fresh-id counter, search and result register.
  bba_dp #(
    .NUM_BLOCKS     (NUM_BLOCKS),
    .SCAN_WORD_BITS (SCAN_WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

[hdl/bba_checker.sv]
// Port-level checks of the bitmap block allocator, bound to its top level.
// Depends on bba_pkg and bitmap_block_allocator_top_assert.svh.
`include "bitmap_block_allocator_top_assert.svh"

module bba_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          rsp_valid_o,
  input bba_pkg::rsp_t rsp_o
);

  // An accepted item holds off the next one.
  `BBA_ASSERT(a_accept_busy, start && !busy |=> busy, "busy not raised after accept")

  // A result only closes an item in flight.
  `BBA_ASSERT(a_rsp_after_busy, rsp_valid_o |-> $past(busy), "result without an item")

  // Error only rides on a handed-out block.
  `BBA_ASSERT(a_err_found, rsp_valid_o && rsp_o.error |-> rsp_o.found, "error without found")

  // Not-found carries id zero.
  `BBA_ASSERT(a_miss_zero, rsp_valid_o && !rsp_o.found |-> rsp_o.alloc_id == '0, "miss with id")

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);
